// ===== rtl/core/mi4_pkg.sv =====
// Shared types and constants for the 4x4 matrix inverse unit.
// No dependencies; imported by mi4_fpu and matrix_inverse_4x4_unit.
`default_nettype none

package mi4_pkg;

   // Operations of the shared float unit (RECIP computes 1/b, a is ignored)
   typedef enum logic [1:0] {
      FOP_ADD,
      FOP_SUB,
      FOP_MUL,
      FOP_RECIP
   } fop_type;

   typedef struct packed {
      logic        start;
      fop_type     op;
      logic [31:0] a;
      logic [31:0] b;
   } fpu_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } fpu_rsp_type;

   localparam logic [31:0] ONE_BITS    = 32'h3F80_0000;
   localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
   localparam logic [31:0] EPS_RESET   = 32'h3727_C5AC;

   // Register index decoded from the word address
   localparam logic [0:0] REG_EPSILON = 1'b0;

endpackage

`default_nettype wire

// ===== rtl/core/mi4_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mi4_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic      [WIDTH-1:0]         rdata_a,
   output logic      [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

`default_nettype wire

// ===== rtl/core/mi4_fpu.sv =====
// Multi-cycle IEEE single float unit: add, subtract, multiply, reciprocal.
// Round to nearest even, subnormals kept. Depends on mi4_pkg.
`default_nettype none

module mi4_fpu
   import mi4_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire fpu_req_type req,
   output fpu_rsp_type      rsp
);

   typedef enum logic [2:0] {
      F_IDLE,
      F_DIVIDE,
      F_NORM,
      F_DENORM,
      F_ROUND
   } fstate_type;

   fstate_type         state_ff, state_in;
   logic [49:0]        m_ff, m_in;
   logic signed [11:0] ex_ff, ex_in;
   logic               sgn_ff, sgn_in;
   logic               st_ff, st_in;
   logic [23:0]        rem_ff, rem_in;
   logic [23:0]        dv_ff, dv_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [31:0]        res_ff, res_in;

   // operand decode
   logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic [23:0]        ma, mb;
   logic signed [11:0] ea, eb;
   logic [31:0]        a_q, b_q;
   logic [47:0]        prod;

   // add path
   logic               bs, a_ge, sbig, ssml;
   logic [23:0]        mbig, msml;
   logic signed [11:0] ebig, esml, dexp;
   logic [49:0]        big_m, sml_m, sh, aligned, sum;
   logic               lost;

   // divide step
   logic [24:0]        remsh;
   logic               qbit;
   logic [23:0]        rem_nx;

   // rounding
   logic [23:0]        mant24;
   logic               rnd_g, rnd_s, rnd_inc;
   logic [24:0]        mant25;
   logic signed [11:0] efield;

   always_comb begin
      a_nan  = (&req.a[30:23]) && (|req.a[22:0]);
      b_nan  = (&req.b[30:23]) && (|req.b[22:0]);
      a_inf  = (&req.a[30:23]) && !(|req.a[22:0]);
      b_inf  = (&req.b[30:23]) && !(|req.b[22:0]);
      a_zero = (req.a[30:0] == 31'd0);
      b_zero = (req.b[30:0] == 31'd0);
      ma     = {|req.a[30:23], req.a[22:0]};
      mb     = {|req.b[30:23], req.b[22:0]};
      ea     = (req.a[30:23] == 8'd0) ? 12'sd1 : $signed({4'b0, req.a[30:23]});
      eb     = (req.b[30:23] == 8'd0) ? 12'sd1 : $signed({4'b0, req.b[30:23]});
      a_q    = req.a | 32'h0040_0000;
      b_q    = req.b | 32'h0040_0000;
      prod   = ma * mb;

      bs    = req.b[31] ^ (req.op == FOP_SUB);
      a_ge  = (req.a[30:0] >= req.b[30:0]);
      mbig  = a_ge ? ma : mb;
      msml  = a_ge ? mb : ma;
      ebig  = a_ge ? ea : eb;
      esml  = a_ge ? eb : ea;
      sbig  = a_ge ? req.a[31] : bs;
      ssml  = a_ge ? bs : req.a[31];
      dexp  = ebig - esml;
      big_m = {1'b0, mbig, 25'b0};
      sml_m = {1'b0, msml, 25'b0};
      if (dexp < 12'sd50) begin
         sh   = sml_m >> dexp[5:0];
         lost = ((sh << dexp[5:0]) != sml_m);
      end else begin
         sh   = 50'd0;
         lost = |msml;
      end
      aligned = {sh[49:1], sh[0] | lost};
      sum     = (sbig == ssml) ? (big_m + aligned) : (big_m - aligned);

      remsh  = {rem_ff, (cnt_ff == 6'd49)};
      qbit   = (remsh >= {1'b0, dv_ff});
      rem_nx = qbit ? 24'(remsh - {1'b0, dv_ff}) : remsh[23:0];

      mant24  = m_ff[49:26];
      rnd_g   = m_ff[25];
      rnd_s   = (|m_ff[24:0]) | st_ff;
      rnd_inc = rnd_g & (rnd_s | mant24[0]);
      mant25  = {1'b0, mant24} + {24'd0, rnd_inc};
      efield  = mant25[24] ? (ex_ff + 12'sd1) : (mant25[23] ? ex_ff : 12'sd0);
   end

   always_comb begin
      state_in = state_ff;
      m_in     = m_ff;
      ex_in    = ex_ff;
      sgn_in   = sgn_ff;
      st_in    = st_ff;
      rem_in   = rem_ff;
      dv_in    = dv_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      case (state_ff)
         F_IDLE: begin
            if (req.start) begin
               st_in = 1'b0;
               case (req.op)
                  FOP_MUL: begin
                     done_in = 1'b1;
                     if (a_nan) begin
                        res_in = a_q;
                     end else if (b_nan) begin
                        res_in = b_q;
                     end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                        res_in = DEFAULT_NAN;
                     end else if (a_inf || b_inf) begin
                        res_in = {req.a[31] ^ req.b[31], 8'hFF, 23'd0};
                     end else if (a_zero || b_zero) begin
                        res_in = {req.a[31] ^ req.b[31], 31'd0};
                     end else begin
                        done_in  = 1'b0;
                        m_in     = {prod, 2'b00};
                        ex_in    = ea + eb - 12'sd126;
                        sgn_in   = req.a[31] ^ req.b[31];
                        state_in = F_NORM;
                     end
                  end
                  FOP_ADD, FOP_SUB: begin
                     done_in = 1'b1;
                     if (a_nan) begin
                        res_in = a_q;
                     end else if (b_nan) begin
                        res_in = b_q;
                     end else if (a_inf && b_inf && (req.a[31] != bs)) begin
                        res_in = DEFAULT_NAN;
                     end else if (a_inf) begin
                        res_in = req.a;
                     end else if (b_inf) begin
                        res_in = {bs, req.b[30:0]};
                     end else if (a_zero && b_zero) begin
                        res_in = {req.a[31] & bs, 31'd0};
                     end else if (sum == 50'd0) begin
                        res_in = 32'd0;
                     end else begin
                        done_in  = 1'b0;
                        m_in     = sum;
                        ex_in    = ebig + 12'sd1;
                        sgn_in   = sbig;
                        state_in = F_NORM;
                     end
                  end
                  FOP_RECIP: begin
                     done_in = 1'b1;
                     if (b_nan) begin
                        res_in = b_q;
                     end else if (b_inf) begin
                        res_in = {req.b[31], 31'd0};
                     end else if (b_zero) begin
                        res_in = {req.b[31], 8'hFF, 23'd0};
                     end else begin
                        done_in  = 1'b0;
                        m_in     = 50'd0;
                        rem_in   = 24'd0;
                        dv_in    = mb;
                        cnt_in   = 6'd49;
                        sgn_in   = req.b[31];
                        ex_in    = 12'sd277 - eb;
                        state_in = F_DIVIDE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         F_DIVIDE: begin
            // one quotient bit a cycle, 50 in all
            m_in   = {m_ff[48:0], qbit};
            rem_in = rem_nx;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               st_in    = (rem_nx != 24'd0);
               state_in = F_NORM;
            end
         end
         F_NORM: begin
            if (m_ff[49]) begin
               state_in = (ex_ff >= 12'sd1) ? F_ROUND : F_DENORM;
            end else if (m_ff[49:34] == 16'd0) begin
               m_in  = {m_ff[33:0], 16'd0};
               ex_in = ex_ff - 12'sd16;
            end else if (m_ff[49:46] == 4'd0) begin
               m_in  = {m_ff[45:0], 4'd0};
               ex_in = ex_ff - 12'sd4;
            end else begin
               m_in  = {m_ff[48:0], 1'b0};
               ex_in = ex_ff - 12'sd1;
            end
         end
         F_DENORM: begin
            if (ex_ff >= 12'sd1) begin
               state_in = F_ROUND;
            end else if (ex_ff <= -12'sd15) begin
               m_in  = {16'd0, m_ff[49:16]};
               st_in = st_ff | (|m_ff[15:0]);
               ex_in = ex_ff + 12'sd16;
            end else begin
               m_in  = {1'b0, m_ff[49:1]};
               st_in = st_ff | m_ff[0];
               ex_in = ex_ff + 12'sd1;
            end
         end
         F_ROUND: begin
            done_in  = 1'b1;
            state_in = F_IDLE;
            if (efield >= 12'sd255) begin
               res_in = {sgn_ff, 8'hFF, 23'd0};
            end else begin
               res_in = {sgn_ff, efield[7:0], mant25[24] ? 23'd0 : mant25[22:0]};
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      m_ff   <= m_in;
      ex_ff  <= ex_in;
      sgn_ff <= sgn_in;
      st_ff  <= st_in;
      rem_ff <= rem_in;
      dv_ff  <= dv_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

endmodule

`default_nettype wire

// ===== rtl/core/matrix_inverse_4x4_unit.sv =====
// Top level of the 4x4 single-precision matrix inverse (cofactor / adjugate).
// Depends on mi4_pkg, mi4_ram and mi4_fpu.
//
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_stall   req_element_bits[31:0]
// rsp       out        rsp_valid / rsp_stall   rsp_result_bits[31:0], rsp_singular,
//                                              rsp_final_flag
// csr       in         APB psel/penable/pready epsilon threshold at word 0
//
// Element requests are taken while req_stall is low; the 16th starts the solve,
// during which req_stall stays high. The solve runs 248 float operations one
// after another through the single shared float unit (mi4_fpu); for a matrix
// flagged singular the reciprocal and output multiplies are skipped. Each one passes
// the sequencer states fetch and issue, then waits for the unit: a special operand
// is answered directly, a multiply or add is normalized and rounded (longer with
// deep cancellation or subnormals), the reciprocal runs a bit-serial divide first.
// Reset is synchronous, clears the sequencer and load slot and reloads the default
// threshold; no clearing pass is needed. A stalled response holds its payload.
`default_nettype none

module matrix_inverse_4x4_unit
   import mi4_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // element requests
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_element_bits,
   // inverse elements
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_result_bits,
   output logic             rsp_singular,
   output logic             rsp_final_flag,
   // configuration
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   typedef enum logic [2:0] {
      S_LOAD,
      S_FETCH,
      S_ISSUE,
      S_WAIT,
      S_CHECK,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_COF,
      PH_DET,
      PH_DIV,
      PH_OUT
   } phase_type;

   typedef enum logic [2:0] {
      D_P0,
      D_P1,
      D_T0,
      D_T1,
      D_COF,
      D_RECIP,
      D_OUT
   } dest_type;

   localparam logic [3:0] LAST_STEP_COF = 4'd13;
   localparam logic [3:0] LAST_STEP_DET = 4'd6;

   // Element index of minor entry k for cofactor c: skip group c[3:2] and lane c[1:0]
   function automatic logic [3:0] nidx(input logic [3:0] c, input logic [3:0] k);
      logic [1:0] r, s, gr, lc;
      if (k >= 4'd6) begin
         r = 2'd2;
         s = 2'(k - 4'd6);
      end else if (k >= 4'd3) begin
         r = 2'd1;
         s = 2'(k - 4'd3);
      end else begin
         r = 2'd0;
         s = k[1:0];
      end
      gr = r + {1'b0, (r >= c[3:2])};
      lc = s + {1'b0, (s >= c[1:0])};
      return {gr, lc};
   endfunction

   // IEEE a <= b, false when either is NaN
   function automatic logic fle(input logic [31:0] a, input logic [31:0] b);
      logic a_nan, b_nan, le;
      a_nan = (&a[30:23]) && (|a[22:0]);
      b_nan = (&b[30:23]) && (|b[22:0]);
      if (a_nan || b_nan) begin
         le = 1'b0;
      end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
         le = 1'b1;
      end else if (a[31] != b[31]) begin
         le = a[31];
      end else if (a[31]) begin
         le = (a[30:0] >= b[30:0]);
      end else begin
         le = (a[30:0] <= b[30:0]);
      end
      return le;
   endfunction

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [3:0]  idx_ff, idx_in;       // cofactor index, then output index
   logic [3:0]  step_ff, step_in;
   logic [3:0]  load_count_ff, load_count_in;
   logic [31:0] eps_ff, eps_in;
   logic        sing_ff, sing_in;
   logic [31:0] p0_ff, p0_in, p1_ff, p1_in, t0_ff, t0_in, t1_ff, t1_in;
   logic [31:0] recip_ff, recip_in;
   logic [31:0] cof_ff [16];
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_result_ff, rsp_result_in;
   logic        rsp_singular_ff, rsp_singular_in;
   logic        rsp_final_ff, rsp_final_in;

   logic        req_accept, csr_write;
   logic        cof_we;
   logic [3:0]  ka, kb, addr_a, addr_b, cof_rd;
   logic [1:0]  di;
   logic [31:0] ram_a, ram_b, cof_val;
   fop_type     op;
   logic [31:0] opa, opb;
   dest_type    dest;
   logic        bypass;
   fpu_req_type fpu_req;
   fpu_rsp_type fpu_rsp;

   assign req_accept = req_valid && !req_stall;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   mi4_ram #(
      .WIDTH (32),
      .DEPTH (16)
   ) u_store (
      .clock   (clock),
      .we      (req_accept),
      .waddr   (load_count_ff),
      .wdata   (req_element_bits),
      .raddr_a (addr_a),
      .raddr_b (addr_b),
      .rdata_a (ram_a),
      .rdata_b (ram_b)
   );

   mi4_fpu u_fpu (
      .clock (clock),
      .reset (reset),
      .req   (fpu_req),
      .rsp   (fpu_rsp)
   );

   // Operation decode: what to run for the current phase and step
   always_comb begin
      ka     = 4'd0;
      kb     = 4'd0;
      addr_a = 4'd0;
      addr_b = 4'd0;
      di     = 2'(({1'b0, step_ff} + 5'd1) >> 1);
      cof_rd = {2'b00, di};
      op     = FOP_MUL;
      opa    = ram_a;
      opb    = ram_b;
      dest   = D_P0;
      case (phase_ff)
         PH_COF: begin
            // minor = n0*(n4*n8 - n5*n7) - n1*(n3*n8 - n5*n6) + n2*(n3*n7 - n4*n6)
            case (step_ff)
               4'd0:  begin ka = 4'd4; kb = 4'd8; dest = D_P0; end
               4'd1:  begin ka = 4'd5; kb = 4'd7; dest = D_P1; end
               4'd2:  begin op = FOP_SUB; opa = p0_ff; opb = p1_ff; dest = D_P0; end
               4'd3:  begin ka = 4'd0; opb = p0_ff; dest = D_T0; end
               4'd4:  begin ka = 4'd3; kb = 4'd8; dest = D_P0; end
               4'd5:  begin ka = 4'd5; kb = 4'd6; dest = D_P1; end
               4'd6:  begin op = FOP_SUB; opa = p0_ff; opb = p1_ff; dest = D_P0; end
               4'd7:  begin ka = 4'd1; opb = p0_ff; dest = D_T1; end
               4'd8:  begin ka = 4'd3; kb = 4'd7; dest = D_P0; end
               4'd9:  begin ka = 4'd4; kb = 4'd6; dest = D_P1; end
               4'd10: begin op = FOP_SUB; opa = p0_ff; opb = p1_ff; dest = D_P0; end
               4'd11: begin ka = 4'd2; opb = p0_ff; dest = D_P0; end
               4'd12: begin op = FOP_SUB; opa = t0_ff; opb = t1_ff; dest = D_T0; end
               4'd13: begin op = FOP_ADD; opa = t0_ff; opb = p0_ff; dest = D_COF; end
               default: ;
            endcase
            addr_a = nidx(idx_ff, ka);
            addr_b = nidx(idx_ff, kb);
         end
         PH_DET: begin
            // det = ((e0*c0 - e1*c1) + e2*c2) - e3*c3, accumulated in t0
            addr_a = {2'b00, di};
            opb    = cof_val;
            case (step_ff)
               4'd0:    dest = D_T0;
               4'd2:    begin op = FOP_SUB; opa = t0_ff; opb = p0_ff; dest = D_T0; end
               4'd4:    begin op = FOP_ADD; opa = t0_ff; opb = p0_ff; dest = D_T0; end
               4'd6:    begin op = FOP_SUB; opa = t0_ff; opb = p0_ff; dest = D_T0; end
               default: dest = D_P0;
            endcase
         end
         PH_DIV: begin
            op   = FOP_RECIP;
            opa  = ONE_BITS;
            opb  = t0_ff;
            dest = D_RECIP;
         end
         PH_OUT: begin
            // inverse[a][b] = +-recip * cof[b][a], negated where a + b is odd
            cof_rd = {idx_ff[1:0], idx_ff[3:2]};
            opa    = {recip_ff[31] ^ idx_ff[2] ^ idx_ff[0], recip_ff[30:0]};
            opb    = cof_val;
            dest   = D_OUT;
         end
         default: ;
      endcase
   end

   assign cof_val = cof_ff[cof_rd];
   assign bypass  = (phase_ff == PH_OUT) && sing_ff;

   always_comb begin
      fpu_req.start = (state_ff == S_ISSUE) && !bypass;
      fpu_req.op    = op;
      fpu_req.a     = opa;
      fpu_req.b     = opb;
   end

   // Sequencer
   always_comb begin
      state_in        = state_ff;
      phase_in        = phase_ff;
      idx_in          = idx_ff;
      step_in         = step_ff;
      load_count_in   = load_count_ff;
      eps_in          = eps_ff;
      sing_in         = sing_ff;
      p0_in           = p0_ff;
      p1_in           = p1_ff;
      t0_in           = t0_ff;
      t1_in           = t1_ff;
      recip_in        = recip_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_result_in   = rsp_result_ff;
      rsp_singular_in = rsp_singular_ff;
      rsp_final_in    = rsp_final_ff;
      cof_we          = 1'b0;

      if (csr_write && (csr_paddr[2:2] == REG_EPSILON)) begin
         eps_in = csr_pwdata;
      end

      case (state_ff)
         S_LOAD: begin
            // take elements; the 16th starts the solve
            if (req_accept) begin
               load_count_in = load_count_ff + 4'd1;
               if (load_count_ff == 4'd15) begin
                  phase_in = PH_COF;
                  idx_in   = 4'd0;
                  step_in  = 4'd0;
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            // store read addresses settle here; data is registered for issue
            state_in = S_ISSUE;
         end
         S_ISSUE: begin
            if (bypass) begin
               rsp_valid_in    = 1'b1;
               rsp_result_in   = (idx_ff[3:2] == idx_ff[1:0]) ? ONE_BITS : 32'd0;
               rsp_singular_in = 1'b1;
               rsp_final_in    = (idx_ff == 4'd15);
               state_in        = S_EMIT;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (fpu_rsp.done) begin
               case (dest)
                  D_P0:    p0_in = fpu_rsp.result;
                  D_P1:    p1_in = fpu_rsp.result;
                  D_T0:    t0_in = fpu_rsp.result;
                  D_T1:    t1_in = fpu_rsp.result;
                  D_COF:   cof_we = 1'b1;
                  D_RECIP: recip_in = fpu_rsp.result;
                  D_OUT: begin
                     rsp_valid_in    = 1'b1;
                     rsp_result_in   = fpu_rsp.result;
                     rsp_singular_in = 1'b0;
                     rsp_final_in    = (idx_ff == 4'd15);
                  end
                  default: ;
               endcase
               state_in = S_FETCH;
               case (phase_ff)
                  PH_COF: begin
                     step_in = step_ff + 4'd1;
                     if (step_ff == LAST_STEP_COF) begin
                        step_in = 4'd0;
                        idx_in  = idx_ff + 4'd1;
                        if (idx_ff == 4'd15) begin
                           phase_in = PH_DET;
                        end
                     end
                  end
                  PH_DET: begin
                     step_in = step_ff + 4'd1;
                     if (step_ff == LAST_STEP_DET) begin
                        state_in = S_CHECK;
                     end
                  end
                  PH_DIV: begin
                     phase_in = PH_OUT;
                     idx_in   = 4'd0;
                  end
                  PH_OUT: state_in = S_EMIT;
                  default: ;
               endcase
            end
         end
         S_CHECK: begin
            // |det| <= epsilon: emit the identity instead of the inverse
            sing_in  = fle({1'b0, t0_ff[30:0]}, eps_ff);
            idx_in   = 4'd0;
            phase_in = fle({1'b0, t0_ff[30:0]}, eps_ff) ? PH_OUT : PH_DIV;
            state_in = S_FETCH;
         end
         S_EMIT: begin
            // hold the result until taken
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               idx_in       = idx_ff + 4'd1;
               state_in     = (idx_ff == 4'd15) ? S_LOAD : S_FETCH;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         phase_ff      <= PH_COF;
         idx_ff        <= 4'd0;
         step_ff       <= 4'd0;
         load_count_ff <= 4'd0;
         eps_ff        <= EPS_RESET;
         sing_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         idx_ff        <= idx_in;
         step_ff       <= step_in;
         load_count_ff <= load_count_in;
         eps_ff        <= eps_in;
         sing_ff       <= sing_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      p0_ff           <= p0_in;
      p1_ff           <= p1_in;
      t0_ff           <= t0_in;
      t1_ff           <= t1_in;
      recip_ff        <= recip_in;
      rsp_result_ff   <= rsp_result_in;
      rsp_singular_ff <= rsp_singular_in;
      rsp_final_ff    <= rsp_final_in;
      if (cof_we) begin
         cof_ff[idx_ff] <= fpu_rsp.result;
      end
   end

   assign req_stall       = (state_ff != S_LOAD);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_bits = rsp_result_ff;
   assign rsp_singular    = rsp_singular_ff;
   assign rsp_final_flag  = rsp_final_ff;
   assign csr_pready      = 1'b1;
   assign csr_prdata      = (csr_paddr[2:2] == REG_EPSILON) ? eps_ff : 32'd0;

endmodule

`default_nettype wire

// ===== verif/matrix_inverse_4x4_unit_test.sv =====
// Self-checking testbench for matrix_inverse_4x4_unit: streams 4x4 float matrices,
// predicts each inverse with a bit-exact single-precision model of its own.
// Depends on mi4_pkg and the RTL of matrix_inverse_4x4_unit only.
`timescale 1ns / 1ps

module matrix_inverse_4x4_unit_test
   import mi4_pkg::*;
;

   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [2:0] EPSILON_ADDR = {REG_EPSILON, 2'b00};
   localparam logic [2:0] UNMAPPED_ADDR = 3'd4;
   localparam logic [31:0] POS_INF = 32'h7F80_0000;

   typedef enum logic [1:0] {
      CHECK_PREDICTED,
      CHECK_IDENTITY_SINGULAR
   } check_kind_type;

   typedef enum logic [2:0] {
      GEN_SMALL_INT,
      GEN_MODERATE,
      GEN_RAW_BITS,
      GEN_REPEATED_ROW,
      GEN_TINY
   } gen_kind_type;

   typedef struct {
      logic [31:0] elem [16];
      check_kind_type check;
   } directed_matrix_type;

   typedef struct packed {
      logic [31:0] value;
      logic        singular;
      logic        final_flag;
   } inverse_elem_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_element_bits = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_result_bits;
   logic        rsp_singular;
   logic        rsp_final_flag;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state: loaded elements, load slot, and threshold
   logic [31:0] held_elements [16];
   logic [3:0]  next_slot = '0;
   logic [31:0] threshold_bits = EPS_RESET;

   inverse_elem_type pending_inverse [$];
   int error_count = 0;
   int cycle_count = 0;
   int burst_left = 0;

   // receiver stall pattern
   int stall_mode = 0;
   int stall_span = 0;

   matrix_inverse_4x4_unit u_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_element_bits,
      .rsp_valid, .rsp_stall, .rsp_result_bits, .rsp_singular, .rsp_final_flag,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- float math
   function automatic bit is_nan(logic [31:0] f);
      return f[30:23] == 8'hFF && f[22:0] != 0;
   endfunction

   function automatic bit is_inf(logic [31:0] f);
      return f[30:0] == POS_INF[30:0];
   endfunction

   function automatic bit is_zero(logic [31:0] f);
      return f[30:0] == 0;
   endfunction

   function automatic logic [63:0] sig_of(logic [31:0] f);
      return (f[30:23] == 0) ? {41'd0, f[22:0]} : {40'd0, 1'b1, f[22:0]};
   endfunction

   function automatic int exp_of(logic [31:0] f);
      return ((f[30:23] == 0) ? 1 : int'(f[30:23])) - 150;
   endfunction

   // Round sign * mag * 2^scale to single, nearest even, subnormals kept.
   function automatic logic [31:0] round_single(bit sgn, int scale, logic [63:0] mag);
      int top;
      int biased;
      int shift;
      logic [63:0] kept;
      logic [63:0] packed_bits;
      bit half;
      bit sticky;
      top = 63;
      while (!mag[top]) top--;
      biased = top + scale + 127;
      shift = (biased >= 1) ? top - 23 : top - 23 + (1 - biased);
      if (shift <= 0) begin
         kept = mag << (-shift);
      end else if (shift > 64) begin
         kept = 0;
      end else begin
         kept = (shift == 64) ? 64'd0 : mag >> shift;
         half = mag[shift - 1];
         sticky = (mag & ((64'd1 << (shift - 1)) - 1)) != 0;
         if (half && (sticky || kept[0])) kept++;
      end
      packed_bits = (64'((biased >= 1) ? biased - 1 : 0) << 23) + kept;
      if (biased > 254 || packed_bits >= 64'h7F80_0000) return {sgn, POS_INF[30:0]};
      return {sgn, packed_bits[30:0]};
   endfunction

   function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
      bit sgn;
      sgn = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return DEFAULT_NAN;
      if (is_inf(a) || is_inf(b)) begin
         if (is_zero(a) || is_zero(b)) return DEFAULT_NAN;
         return {sgn, POS_INF[30:0]};
      end
      if (is_zero(a) || is_zero(b)) return {sgn, 31'd0};
      return round_single(sgn, exp_of(a) + exp_of(b), sig_of(a) * sig_of(b));
   endfunction

   function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
      logic [31:0] big;
      logic [31:0] lil;
      logic [63:0] big_m;
      logic [63:0] lil_m;
      logic [63:0] total;
      int gap;
      if (is_nan(a) || is_nan(b)) return DEFAULT_NAN;
      if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? DEFAULT_NAN : a;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
      if (a[30:0] >= b[30:0]) begin
         big = a;
         lil = b;
      end else begin
         big = b;
         lil = a;
      end
      gap = exp_of(big) - exp_of(lil);
      big_m = sig_of(big) << 38;
      if (gap <= 38) begin
         lil_m = sig_of(lil) << (38 - gap);
      end else if (gap - 38 >= 64) begin
         lil_m = (sig_of(lil) != 0);
      end else begin
         lil_m = sig_of(lil) >> (gap - 38);
         if ((lil_m << (gap - 38)) != sig_of(lil)) lil_m[0] = 1'b1;
      end
      total = (big[31] == lil[31]) ? big_m + lil_m : big_m - lil_m;
      if (total == 0) return 32'd0;
      return round_single(big[31], exp_of(big) - 38, total);
   endfunction

   function automatic logic [31:0] f_sub(logic [31:0] a, logic [31:0] b);
      return f_add(a, {~b[31], b[30:0]});
   endfunction

   function automatic logic [31:0] f_recip(logic [31:0] b);
      logic [63:0] quo;
      if (is_nan(b)) return DEFAULT_NAN;
      if (is_inf(b)) return {b[31], 31'd0};
      if (is_zero(b)) return {b[31], POS_INF[30:0]};
      quo = (64'd1 << 62) / sig_of(b);
      if (quo * sig_of(b) != (64'd1 << 62)) quo[0] = 1'b1;
      return round_single(b[31], -62 - exp_of(b), quo);
   endfunction

   // |det| <= threshold, false on any NaN
   function automatic bit below_threshold(logic [31:0] det, logic [31:0] thr);
      logic [31:0] mag;
      mag = {1'b0, det[30:0]};
      if (is_nan(mag) || is_nan(thr)) return 1'b0;
      if (thr[31]) return is_zero(mag) && is_zero(thr);
      return mag <= thr;
   endfunction

   // ---------------------------------------------------------------- predictor
   function automatic logic [31:0] cofactor(int grp, int lane);
      logic [31:0] n [9];
      logic [31:0] p [6];
      logic [31:0] t0;
      logic [31:0] t1;
      logic [31:0] t2;
      int k;
      k = 0;
      for (int g = 0; g < 4; g++)
         for (int l = 0; l < 4; l++)
            if (g != grp && l != lane) begin
               n[k] = held_elements[g * 4 + l];
               k++;
            end
      p[0] = f_mul(n[4], n[8]);
      p[1] = f_mul(n[5], n[7]);
      p[2] = f_mul(n[3], n[8]);
      p[3] = f_mul(n[5], n[6]);
      p[4] = f_mul(n[3], n[7]);
      p[5] = f_mul(n[4], n[6]);
      t0 = f_mul(n[0], f_sub(p[0], p[1]));
      t1 = f_mul(n[1], f_sub(p[2], p[3]));
      t2 = f_mul(n[2], f_sub(p[4], p[5]));
      return f_add(f_sub(t0, t1), t2);
   endfunction

   // Push the 16 expected inverse elements of the held matrix.
   task automatic predict_inverse(check_kind_type check);
      logic [31:0] cof [16];
      logic [31:0] det;
      logic [31:0] recip;
      logic [31:0] scale;
      bit singular;
      inverse_elem_type item;
      for (int i = 0; i < 16; i++) cof[i] = cofactor(i >> 2, i & 3);
      det = f_mul(held_elements[0], cof[0]);
      det = f_sub(det, f_mul(held_elements[1], cof[1]));
      det = f_add(det, f_mul(held_elements[2], cof[2]));
      det = f_sub(det, f_mul(held_elements[3], cof[3]));
      singular = below_threshold(det, threshold_bits);
      recip = f_recip(det);
      if (check == CHECK_IDENTITY_SINGULAR) singular = 1'b1;
      for (int i = 0; i < 16; i++) begin
         item.singular = singular;
         item.final_flag = (i == 15);
         if (check != CHECK_PREDICTED || singular) begin
            // typed in: identity bits on the diagonal
            item.value = ((i >> 2) == (i & 3)) ? ONE_BITS : 32'd0;
         end else begin
            scale = (((i >> 2) + (i & 3)) & 1) ? {~recip[31], recip[30:0]} : recip;
            item.value = f_mul(scale, cof[(i & 3) * 4 + (i >> 2)]);
         end
         pending_inverse.push_back(item);
      end
   endtask

   // ---------------------------------------------------------------- request side
   // Drive one element request and hold it until accepted; record it on accept.
   task automatic send_element(logic [31:0] bits, check_kind_type check);
      int idle_cycles;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         idle_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (idle_cycles > 0) begin
            req_valid <= 1'b0;
            repeat (idle_cycles) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_element_bits <= bits;
      do @(posedge clock); while (req_stall);
      held_elements[next_slot] = bits;
      next_slot++;
      if (next_slot == 0) predict_inverse(check);
   endtask

   task automatic send_matrix(logic [31:0] elem [16], check_kind_type check);
      for (int i = 0; i < 16; i++) send_element(elem[i], check);
   endtask

   // Drain all outstanding inverse elements, then let the solver settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_inverse.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] addr, logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == EPSILON_ADDR) threshold_bits = data;
   endtask

   function automatic logic [31:0] int_to_single(int v);
      if (v == 0) return 32'd0;
      return round_single(v < 0, 0, 64'((v < 0) ? -v : v));
   endfunction

   function automatic logic [31:0] random_element(gen_kind_type kind);
      case (kind)
         GEN_SMALL_INT, GEN_REPEATED_ROW: begin
            return int_to_single($urandom_range(0, 16) - 8);
         end
         GEN_MODERATE: begin
            return {1'($urandom_range(0, 1)), 8'($urandom_range(118, 136)),
                    23'($urandom)};
         end
         GEN_RAW_BITS: begin
            return $urandom;
         end
         default: begin
            return {1'($urandom_range(0, 1)), 8'($urandom_range(0, 12)), 23'($urandom)};
         end
      endcase
   endfunction

   task automatic send_random_matrix(gen_kind_type kind);
      logic [31:0] elem [16];
      int src;
      int dst;
      for (int i = 0; i < 16; i++) elem[i] = random_element(kind);
      if (kind == GEN_REPEATED_ROW) begin
         // copy one group over another so the determinant vanishes
         src = $urandom_range(0, 3);
         dst = (src + $urandom_range(1, 3)) % 4;
         for (int l = 0; l < 4; l++) elem[dst * 4 + l] = elem[src * 4 + l];
      end
      send_matrix(elem, CHECK_PREDICTED);
   endtask

   // ---------------------------------------------------------------- result side
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(20, 300);
         end else begin
            stall_span--;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= 1'($urandom_range(0, 1));
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Compare each accepted inverse element with the oldest expectation.
   always @(posedge clock) begin
      inverse_elem_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_inverse.size() == 0) begin
            $display("%0t: unexpected inverse element %h", $time, rsp_result_bits);
            error_count++;
         end else begin
            want = pending_inverse.pop_front();
            if (!(rsp_result_bits == want.value
                  || (is_nan(rsp_result_bits) && is_nan(want.value)))) begin
               $display("%0t: result_bits expected %h actual %h",
                        $time, want.value, rsp_result_bits);
               error_count++;
            end
            if (rsp_singular !== want.singular) begin
               $display("%0t: singular expected %b actual %b",
                        $time, want.singular, rsp_singular);
               error_count++;
            end
            if (rsp_final_flag !== want.final_flag) begin
               $display("%0t: final_flag expected %b actual %b",
                        $time, want.final_flag, rsp_final_flag);
               error_count++;
            end
         end
      end
   end

   // Watchdog: drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------- main flow
   initial begin
      directed_matrix_type directed [4];
      logic [31:0] threshold_plan [8];

      // identity: regular, inverse is the identity up to signed zeros
      // zero: singular, identity flagged
      // largest finite on the diagonal: determinant overflows
      // NaN element: compare fails, NaNs propagate
      foreach (directed[r]) begin
         for (int i = 0; i < 16; i++) directed[r].elem[i] = 32'd0;
      end
      for (int d = 0; d < 4; d++) begin
         directed[0].elem[d * 5] = ONE_BITS;
         directed[2].elem[d * 5] = (d == 1) ? 32'hFF7F_FFFF : 32'h7F7F_FFFF;
         directed[3].elem[d * 5] = int_to_single(d + 2);
      end
      directed[3].elem[6] = 32'h7FC0_0001;
      directed[0].check = CHECK_PREDICTED;
      directed[1].check = CHECK_IDENTITY_SINGULAR;
      directed[2].check = CHECK_PREDICTED;
      directed[3].check = CHECK_PREDICTED;

      // threshold settings: zero, NaN, infinity, negative zero, negative one,
      // largest finite, reset value, random
      threshold_plan[0] = 32'd0;
      threshold_plan[1] = 32'hFFFF_FFFF;
      threshold_plan[2] = POS_INF;
      threshold_plan[3] = 32'h8000_0000;
      threshold_plan[4] = 32'hBF80_0000;
      threshold_plan[5] = 32'h7F7F_FFFF;
      threshold_plan[6] = EPS_RESET;
      threshold_plan[7] = $urandom;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[r]) send_matrix(directed[r].elem, directed[r].check);

      // pause the sender until every inverse element is back
      wait_drained();
      write_csr(UNMAPPED_ADDR, 32'h0000_0000);

      for (int phase = 0; phase < 8; phase++) begin
         wait_drained();
         write_csr(EPSILON_ADDR, threshold_plan[phase]);
         send_random_matrix(GEN_REPEATED_ROW);
         send_random_matrix(gen_kind_type'($urandom_range(0, 4)));
      end
      wait_drained();
      write_csr(EPSILON_ADDR, EPS_RESET);
      send_random_matrix(GEN_TINY);
      send_random_matrix(GEN_RAW_BITS);
      send_random_matrix(GEN_MODERATE);
      send_random_matrix(GEN_SMALL_INT);

      wait_drained();
      repeat (100) @(posedge clock);
      if (error_count == 0 && pending_inverse.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
